@@ rtl/indexed_min_heap_queue_top_defines.svh @@
// Assertion macros shared by the heap queue RTL.
`ifndef INDEXED_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IMHQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/imhq_pkg.sv @@
package imhq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_LOWERED  = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_POPPED   = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [11:0]        node;
    logic [31:0]        key;
    logic signed [31:0] aux;
  } entry_t;

endpackage

@@ rtl/imhq_ram.sv @@
module imhq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/indexed_min_heap_queue_top.sv @@
// Indexed binary min-heap queue, keyed by unsigned Q16.16 arrival time.
// Input channel (in_valid/in_ready): opcode, node_number, time_key, aux_value.
//   Insert adds a node or lowers the key of a held node; pop removes the
//   minimum; clear empties the queue. One result item per input item.
// Output channel (out_valid/out_ready): status, popped entry, count.
// One item is worked at a time; in_ready is high only while idle. Work per item:
//   insert: look up the node's position; a new node is placed at the end and
//   climbs one level per parent compare; a lowered key climbs from its slot;
//   pop: read the top and the last entry, then descend one level per step;
//   clear: one heap read and one table write for each held entry;
//   empty pop or unused opcode: straight to the result.
// After reset a clearing pass writes every position-table entry to zero, with
// in_ready low.
// A finished result sits in the output register; the block takes the next
// item while it waits, but holds its next result until the receiver takes it.
module indexed_min_heap_queue_top
  import imhq_pkg::*;
#(
  parameter int HEAP_DEPTH = 1024,
  parameter int NODE_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [11:0]        node_number,
  input  logic [31:0]        time_key,
  input  logic signed [31:0] aux_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [11:0]        out_node,
  output logic [31:0]        out_key,
  output logic signed [31:0] out_aux,
  output logic [10:0]        count
);

`include "indexed_min_heap_queue_top_defines.svh"

  localparam int HW = $clog2(HEAP_DEPTH);
  localparam int SW = $clog2(HEAP_DEPTH + 1);
  localparam int NW = $clog2(NODE_COUNT);
  localparam int EW = $bits(entry_t);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_INS_POS, S_INS_KEY, S_UP_CHK, S_UP_CMP,
    S_POP_TOP, S_POP_LAST, S_DN_CHK, S_DN_L, S_DN_R,
    S_CLR_RD, S_CLR_WR, S_RESP
  } state_t;

  state_t        state;
  logic [SW-1:0] size;
  logic [SW-1:0] cur_s;
  logic [NW-1:0] init_ctr;
  entry_t        cur;
  entry_t        lch;
  logic [2:0]    st;
  entry_t        top;

  logic          hm_we;
  logic [HW-1:0] hm_waddr, hm_raddr;
  entry_t        hm_wdata, hm_rdata;
  logic          pm_we;
  logic [NW-1:0] pm_waddr, pm_raddr;
  logic [SW-1:0] pm_wdata, pm_rdata;

  logic [SW:0]   cl;
  logic          found, lmove, rmove, pmove;

  imhq_ram #(.W(EW), .D(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
    .raddr(hm_raddr), .rdata(hm_rdata)
  );

  imhq_ram #(.W(SW), .D(NODE_COUNT)) u_pos (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign cl       = {cur_s, 1'b0};
  assign found    = (pm_rdata != '0) && (pm_rdata <= size);
  assign pmove    = hm_rdata.key > cur.key;
  assign lmove    = (lch.key < cur.key) && (lch.key < hm_rdata.key);
  assign rmove    = hm_rdata.key < cur.key;

  // Memory port control; the sift walks keep the entry being placed in cur.
  always_comb begin
    hm_we    = 1'b0;
    hm_waddr = HW'(cur_s - 1'b1);
    hm_wdata = cur;
    hm_raddr = '0;
    pm_we    = 1'b0;
    pm_waddr = NW'(cur.node);
    pm_wdata = cur_s;
    pm_raddr = NW'(node_number);
    case (state)
      S_INIT: begin
        pm_we    = 1'b1;
        pm_waddr = init_ctr;
        pm_wdata = '0;
      end
      S_INS_POS: hm_raddr = HW'(pm_rdata - 1'b1);
      S_UP_CHK: begin
        if (cur_s == SW'(1)) begin
          hm_we = 1'b1;
          pm_we = 1'b1;
        end else begin
          hm_raddr = HW'((cur_s >> 1) - 1'b1);
        end
      end
      S_UP_CMP: begin
        hm_we = 1'b1;
        pm_we = 1'b1;
        if (pmove) begin
          hm_wdata = hm_rdata;
          pm_waddr = NW'(hm_rdata.node);
        end
      end
      S_POP_TOP: begin
        hm_raddr = HW'(size - 1'b1);
        pm_we    = 1'b1;
        pm_waddr = NW'(hm_rdata.node);
        pm_wdata = '0;
      end
      S_DN_CHK: begin
        if (cl <= {1'b0, size}) begin
          hm_raddr = HW'(cl - 1'b1);
        end else begin
          hm_we = 1'b1;
          pm_we = 1'b1;
        end
      end
      S_DN_L: begin
        if ((cl + 1'b1) <= {1'b0, size}) begin
          hm_raddr = HW'(cl);
        end else begin
          hm_we = 1'b1;
          pm_we = 1'b1;
          if (hm_rdata.key < cur.key) begin
            hm_wdata = hm_rdata;
            pm_waddr = NW'(hm_rdata.node);
          end
        end
      end
      S_DN_R: begin
        hm_we = 1'b1;
        pm_we = 1'b1;
        if (lmove) begin
          hm_wdata = lch;
          pm_waddr = NW'(lch.node);
        end else if (rmove) begin
          hm_wdata = hm_rdata;
          pm_waddr = NW'(hm_rdata.node);
        end
      end
      S_CLR_RD: hm_raddr = HW'(cur_s - 1'b1);
      S_CLR_WR: begin
        pm_we    = 1'b1;
        pm_waddr = NW'(hm_rdata.node);
        pm_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      size      <= '0;
      init_ctr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the taken result unless a new one replaces it this cycle
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_ctr <= init_ctr + 1'b1;
          if (init_ctr == NW'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          top      <= '0;
          cur.node <= node_number;
          cur.key  <= time_key;
          cur.aux  <= aux_value;
          cur_s    <= SW'(1);
          if (in_valid) begin
            st    <= ST_IGNORED;
            state <= S_RESP;
            case (opcode)
              OP_INSERT: begin
                if (32'(node_number) < 32'(NODE_COUNT)) begin
                  state <= S_INS_POS;
                end
              end
              OP_POP: begin
                if (size == '0) begin
                  st <= ST_EMPTY;
                end else begin
                  st    <= ST_POPPED;
                  state <= S_POP_TOP;
                end
              end
              OP_CLEAR: begin
                st <= ST_INSERTED;
                if (size != '0) begin
                  state <= S_CLR_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_INS_POS: begin
          if (found) begin
            cur_s <= pm_rdata;
            state <= S_INS_KEY;
          end else if (size == SW'(HEAP_DEPTH)) begin
            st    <= ST_FULL;
            state <= S_RESP;
          end else begin
            size  <= size + 1'b1;
            cur_s <= size + 1'b1;
            st    <= ST_INSERTED;
            state <= S_UP_CHK;
          end
        end
        S_INS_KEY: begin
          if (cur.key < hm_rdata.key) begin
            st    <= ST_LOWERED;
            state <= S_UP_CHK;
          end else begin
            state <= S_RESP;
          end
        end
        S_UP_CHK: state <= (cur_s == SW'(1)) ? S_RESP : S_UP_CMP;
        S_UP_CMP: begin
          if (pmove) begin
            cur_s <= cur_s >> 1;
            state <= S_UP_CHK;
          end else begin
            state <= S_RESP;
          end
        end
        S_POP_TOP: begin
          top   <= hm_rdata;
          state <= S_POP_LAST;
        end
        S_POP_LAST: begin
          cur   <= hm_rdata;
          size  <= size - 1'b1;
          state <= (size == SW'(1)) ? S_RESP : S_DN_CHK;
        end
        S_DN_CHK: state <= (cl <= {1'b0, size}) ? S_DN_L : S_RESP;
        S_DN_L: begin
          lch <= hm_rdata;
          if ((cl + 1'b1) <= {1'b0, size}) begin
            state <= S_DN_R;
          end else if (hm_rdata.key < cur.key) begin
            cur_s <= SW'(cl);
            state <= S_DN_CHK;
          end else begin
            state <= S_RESP;
          end
        end
        S_DN_R: begin
          if (lmove) begin
            cur_s <= SW'(cl);
            state <= S_DN_CHK;
          end else if (rmove) begin
            cur_s <= SW'(cl + 1'b1);
            state <= S_DN_CHK;
          end else begin
            state <= S_RESP;
          end
        end
        S_CLR_RD: state <= S_CLR_WR;
        S_CLR_WR: begin
          if (cur_s == size) begin
            size  <= '0;
            state <= S_RESP;
          end else begin
            cur_s <= cur_s + 1'b1;
            state <= S_CLR_RD;
          end
        end
        S_RESP: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= st;
            out_node  <= top.node;
            out_key   <= top.key;
            out_aux   <= top.aux;
            count     <= 11'(size);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IMHQ_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state != S_IDLE,
                    "accepted item did not start work")
  `IMHQ_ASSERT_NOW(a_size_bound, state != S_INIT, size <= SW'(HEAP_DEPTH),
                   "heap size beyond depth")
  `IMHQ_ASSERT_NEXT(a_resp_out, state == S_RESP && (!out_valid || out_ready),
                    out_valid && state == S_IDLE, "result not delivered")

endmodule

@@ tb/sv/heap_queue_checker.sv @@
`timescale 1ns / 100ps
module heap_queue_checker
  import imhq_pkg::*;
#(
  parameter int HEAP_DEPTH = 1024,
  parameter int NODE_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [11:0]        node_number,
  input  logic [31:0]        time_key,
  input  logic signed [31:0] aux_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         status,
  input  logic [11:0]        out_node,
  input  logic [31:0]        out_key,
  input  logic signed [31:0] out_aux,
  input  logic [10:0]        count,
  output int                 fail_count,
  output int                 pending,
  output int                 n_pops,
  output int                 n_full,
  output int                 n_lowered,
  output int                 max_held
);

  typedef struct {
    logic [2:0]  st;
    logic [11:0] node;
    logic [31:0] key;
    logic [31:0] aux;
    logic [10:0] cnt;
  } heap_answer_t;

  entry_t       mirror_heap [1:HEAP_DEPTH];
  int           mirror_slot [NODE_COUNT];
  int           mirror_size;
  heap_answer_t answer_q[$];

  function automatic void swap_entries(int a, int b);
    entry_t t;
    t = mirror_heap[a];
    mirror_heap[a] = mirror_heap[b];
    mirror_heap[b] = t;
    mirror_slot[mirror_heap[a].node] = a;
    mirror_slot[mirror_heap[b].node] = b;
  endfunction

  function automatic void bubble_up(int s);
    while (s >= 2 && mirror_heap[s / 2].key > mirror_heap[s].key) begin
      swap_entries(s, s / 2);
      s = s / 2;
    end
  endfunction

  function automatic void bubble_down(int s);
    int l;
    int r;
    while (2 * s <= mirror_size) begin
      l = 2 * s;
      r = l + 1;
      if (r <= mirror_size) begin
        if (mirror_heap[l].key < mirror_heap[s].key &&
            mirror_heap[l].key < mirror_heap[r].key) begin
          swap_entries(s, l);
          s = l;
        end else if (mirror_heap[r].key < mirror_heap[s].key) begin
          swap_entries(s, r);
          s = r;
        end else break;
      end else if (mirror_heap[l].key < mirror_heap[s].key) begin
        swap_entries(s, l);
        s = l;
      end else break;
    end
  endfunction

  function automatic heap_answer_t apply_request(logic [1:0] op, logic [11:0] nd,
                                                 logic [31:0] k, logic [31:0] ax);
    heap_answer_t a;
    int s;
    a = '{ST_IGNORED, '0, '0, '0, '0};
    if (op == OP_INSERT) begin
      if (nd < NODE_COUNT) begin
        s = mirror_slot[nd];
        if (s != 0 && s <= mirror_size) begin
          if (k < mirror_heap[s].key) begin
            mirror_heap[s].key = k;
            mirror_heap[s].aux = ax;
            bubble_up(s);
            a.st = ST_LOWERED;
          end
        end else if (mirror_size >= HEAP_DEPTH) begin
          a.st = ST_FULL;
        end else begin
          mirror_size++;
          mirror_heap[mirror_size] = '{nd, k, ax};
          mirror_slot[nd] = mirror_size;
          bubble_up(mirror_size);
          a.st = ST_INSERTED;
        end
      end
    end else if (op == OP_POP) begin
      if (mirror_size == 0) begin
        a.st = ST_EMPTY;
      end else begin
        a.node = mirror_heap[1].node;
        a.key = mirror_heap[1].key;
        a.aux = mirror_heap[1].aux;
        swap_entries(1, mirror_size);
        mirror_size--;
        mirror_slot[a.node] = 0;
        bubble_down(1);
        a.st = ST_POPPED;
      end
    end else if (op == OP_CLEAR) begin
      for (int i = 1; i <= mirror_size; i++) mirror_slot[mirror_heap[i].node] = 0;
      mirror_size = 0;
      a.st = ST_INSERTED;
    end
    a.cnt = mirror_size[10:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    n_pops = 0;
    n_full = 0;
    n_lowered = 0;
    max_held = 0;
    mirror_size = 0;
    foreach (mirror_slot[i]) mirror_slot[i] = 0;
  end

  always @(posedge clk) begin
    heap_answer_t a;
    heap_answer_t w;
    if (!rst) begin
      if (in_valid && in_ready) begin
        a = apply_request(opcode, node_number, time_key, aux_value);
        if (a.st == ST_POPPED) n_pops++;
        if (a.st == ST_FULL) n_full++;
        if (a.st == ST_LOWERED) n_lowered++;
        if (mirror_size > max_held) max_held = mirror_size;
        answer_q.push_back(a);
      end
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result item with nothing expected", $realtime);
          fail_count++;
        end else begin
          w = answer_q.pop_front();
          if (status !== w.st) report_mismatch("status", 32'(status), 32'(w.st));
          if (out_node !== w.node)
            report_mismatch("out_node", 32'(out_node), 32'(w.node));
          if (out_key !== w.key) report_mismatch("out_key", out_key, w.key);
          if (out_aux !== w.aux) report_mismatch("out_aux", out_aux, w.aux);
          if (count !== w.cnt) report_mismatch("count", 32'(count), 32'(w.cnt));
        end
      end
      pending = answer_q.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import imhq_pkg::*;

  localparam int HEAP_DEPTH = 1024;
  localparam int NODE_COUNT = 4096;
  localparam int CYCLE_LIMIT = 1500000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         opcode;
  logic [11:0]        node_number;
  logic [31:0]        time_key;
  logic signed [31:0] aux_value;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         status;
  logic [11:0]        out_node;
  logic [31:0]        out_key;
  logic signed [31:0] out_aux;
  logic [10:0]        count;
  int                 fail_count;
  int                 pending;
  int                 n_pops;
  int                 n_full;
  int                 n_lowered;
  int                 max_held;
  int                 cycle_count;
  int                 sent;
  bit                 long_hold;

  indexed_min_heap_queue_top u_dut (.*);

  heap_queue_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: random stalls, a stall-free stretch, and one long hold-off.
  initial begin
    int hold;
    out_ready <= 1'b0;
    long_hold = 0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        for (hold = 0; hold < 3000; hold++) @(posedge clk);
        long_hold = 0;
        out_ready <= 1'b1;
      end else if (sent > 300 && sent < 450) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [11:0] nd, logic [31:0] k,
                           logic [31:0] ax);
    in_valid <= 1'b1;
    opcode <= op;
    node_number <= nd;
    time_key <= k;
    aux_value <= ax;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
  endtask

  task automatic pause_sender(int gap);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Advance the clock before the first check so the last accepted item is already counted.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly inserts and pops over a bounded node range to get key lowerings.
  task automatic random_item(int pop_weight, int node_span);
    int r;
    logic [1:0] op;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    if (r < pop_weight) op = OP_POP;
    else if (r < 98) op = OP_INSERT;
    else if (r == 98) op = OP_CLEAR;
    else op = OP_UNUSED;
    k = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
    send_item(op, 12'($urandom_range(0, node_span)), k, $urandom);
  endtask

  initial begin
    int burst;
    in_valid <= 1'b0;
    opcode <= OP_INSERT;
    node_number <= '0;
    time_key <= '0;
    aux_value <= '0;
    sent = 0;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_POP, 12'd0, 32'd0, 32'd0);
    send_item(OP_INSERT, 12'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 12'hFFF, 32'd0, 32'h8000_0000);
    send_item(OP_INSERT, 12'd5, 32'd100, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 12'd6, 32'd100, 32'd1);
    send_item(OP_INSERT, 12'd7, 32'd100, 32'd2);
    send_item(OP_INSERT, 12'd5, 32'd100, 32'd3);
    send_item(OP_INSERT, 12'd5, 32'd200, 32'd4);
    send_item(OP_INSERT, 12'd0, 32'd50, 32'd5);
    send_item(OP_UNUSED, 12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(OP_POP, 12'd0, 32'd0, 32'd0);
    send_item(OP_POP, 12'd0, 32'd0, 32'd0);
    send_item(OP_POP, 12'd0, 32'd0, 32'd0);
    send_item(OP_CLEAR, 12'd0, 32'd0, 32'd0);
    send_item(OP_POP, 12'd0, 32'd0, 32'd0);
    send_item(OP_INSERT, 12'd9, 32'd7, 32'd7);
    send_item(OP_CLEAR, 12'd0, 32'd0, 32'd0);
    send_item(OP_CLEAR, 12'd0, 32'd0, 32'd0);

    // Fill past capacity, lower a held key while full, then drain.
    for (int i = 0; i < HEAP_DEPTH + 3; i++)
      send_item(OP_INSERT, i[11:0], $urandom_range(1000, 100000), $urandom);
    send_item(OP_INSERT, 12'd17, 32'd0, 32'd99);
    for (int i = 0; i < 6; i++) send_item(OP_POP, '0, '0, '0);
    send_item(OP_CLEAR, 12'd0, 32'd0, 32'd0);

    // Pause until every expected result is in.
    wait_drained();

    // Hold the receiver off while random traffic keeps coming.
    long_hold = 1;
    while (sent < 1100) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst; i++)
        random_item(sent < 1080 ? 30 : 50, sent < 1080 ? 63 : 4095);
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 30));
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d requests: %0d pops, %0d key lowerings, %0d full drops",
             sent, n_pops, n_lowered, n_full);
    $display("peak occupancy %0d entries, long receiver hold-off exercised", max_held);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
